### hdl/vertex_view_projection_transform_assert.svh
// Assertion macros shared by the camera transform block.
`ifndef VERTEX_VIEW_PROJECTION_TRANSFORM_ASSERT_SVH
`define VERTEX_VIEW_PROJECTION_TRANSFORM_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define VVP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vvp assertion failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define VVP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vvp assertion failed");

`endif

### hdl/vvp_pkg.sv
package vvp_pkg;

	// Field widths of packed camera components and internal values.
	localparam int COMP_W     = 20;
	localparam int DIFF_W     = 21;
	localparam int VTX_W      = 32;
	localparam int TT_W       = 53;
	localparam int CX_W       = 64;
	localparam int CY_W       = 42;
	localparam int CZ_W       = 42;
	localparam int CW_W       = 21;
	localparam int CZW_W      = 53;
	localparam int NUM_W      = 120;
	localparam int QUO_W      = 33;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 60;
	localparam int EXT_W      = 40;

	// Pipeline depths.
	localparam int MUL_LAT   = 2;
	localparam int DIV_LAT   = 3 + QUO_W + 1;
	localparam int BACK_LAT  = MUL_LAT + 1 + DIV_LAT;

	// Cycles the coefficient pipeline needs after a register write.
	localparam logic [1:0] SETTLE_CYCLES = 2'd3;

	// Rounding shifts of the four clip components.
	localparam int SHIFT_X   = 36;
	localparam int SHIFT_YZW = 24;

	// Saturation bounds.
	localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_NEG = 32'h8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EYE   = 3'd0,
		REG_DIR   = 3'd1,
		REG_UP    = 3'd2,
		REG_HORZ  = 3'd3,
		REG_VERT  = 3'd4,
		REG_DEPTH = 3'd5
	} cfg_reg_t;

	// Combined view-projection coefficients derived from the camera registers.
	typedef struct packed {
		logic [2:0][CX_W-1:0] cx;
		logic [2:0][CY_W-1:0] cy;
		logic [2:0][CZ_W-1:0] cz;
		logic [2:0][CW_W-1:0] cw;
		logic [CZW_W-1:0]     czw;
		logic [DIFF_W-1:0]    dx;
		logic [DIFF_W-1:0]    dy;
		logic [DIFF_W-1:0]    dz;
		logic                 invalid;
	} coef_t;

	// Translated vertex as it waits in the queue.
	typedef struct packed {
		logic [2:0][TT_W-1:0] tt;
		logic [VTX_W-1:0]     w;
	} vtx_t;

endpackage

### hdl/vvp_cfg.sv
module vvp_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [vvp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vvp_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic [vvp_pkg::CFG_DATA_W-1:0]   eye_position,
	output vvp_pkg::coef_t                   coef,
	output logic                             settling
);
	import vvp_pkg::*;

	logic [CFG_DATA_W-1:0] eye_q, dir_q, up_q;
	logic [EXT_W-1:0]      horz_q, vert_q, depth_q;
	logic [1:0]            settle_q;

	logic signed [DIFF_W-1:0] nd_c [3];
	logic signed [COMP_W-1:0] up_c [3];
	logic signed [COMP_W-1:0] l_c, r_c, t_c, b_c, n_c, f_c;

	logic signed [41:0]        rt_s1 [3];
	logic signed [DIFF_W-1:0]  nd_s1 [3];
	logic signed [COMP_W-1:0]  up_s1 [3];
	logic signed [COMP_W-1:0]  n_s1, f_s1;
	logic signed [DIFF_W-1:0]  lr_s1, bt_s1, fn_s1, dx_s1, dy_s1, dz_s1;
	logic                      invalid_s1;

	logic signed [61:0]        pnr_s2 [3];
	logic signed [41:0]        plr_s2 [3];
	logic signed [39:0]        pnu_s2 [3];
	logic signed [41:0]        pbt_s2 [3];
	logic signed [41:0]        pfnd_s2 [3];
	logic signed [DIFF_W-1:0]  nd_s2 [3];
	logic signed [39:0]        pfn_s2;
	logic signed [DIFF_W-1:0]  dx_s2, dy_s2, dz_s2;
	logic                      invalid_s2;

	coef_t coef_s3;

	// Register file writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_q   <= '0;
			dir_q   <= '0;
			up_q    <= '0;
			horz_q  <= '0;
			vert_q  <= '0;
			depth_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_EYE:   eye_q   <= cfg_data;
				REG_DIR:   dir_q   <= cfg_data;
				REG_UP:    up_q    <= cfg_data;
				REG_HORZ:  horz_q  <= cfg_data[EXT_W-1:0];
				REG_VERT:  vert_q  <= cfg_data[EXT_W-1:0];
				REG_DEPTH: depth_q <= cfg_data[EXT_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold off new vertices until the coefficient pipeline has caught up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_CYCLES;
		end else if (cfg_valid) begin
			settle_q <= SETTLE_CYCLES;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	// Unpack the signed Q8.12 components.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nd_c[i] = -DIFF_W'($signed(dir_q[COMP_W*i +: COMP_W]));
			up_c[i] = $signed(up_q[COMP_W*i +: COMP_W]);
		end
		l_c = $signed(horz_q[COMP_W-1:0]);
		r_c = $signed(horz_q[EXT_W-1:COMP_W]);
		t_c = $signed(vert_q[COMP_W-1:0]);
		b_c = $signed(vert_q[EXT_W-1:COMP_W]);
		n_c = $signed(depth_q[COMP_W-1:0]);
		f_c = $signed(depth_q[EXT_W-1:COMP_W]);
	end

	// First stage: right vector, extent sums and differences.
	always_ff @(posedge clk) begin
		rt_s1[0]   <= (up_c[1] * nd_c[2]) - (up_c[2] * nd_c[1]);
		rt_s1[1]   <= (up_c[2] * nd_c[0]) - (up_c[0] * nd_c[2]);
		rt_s1[2]   <= (up_c[0] * nd_c[1]) - (up_c[1] * nd_c[0]);
		for (int i = 0; i < 3; i++) begin
			nd_s1[i] <= nd_c[i];
			up_s1[i] <= up_c[i];
		end
		n_s1       <= n_c;
		f_s1       <= f_c;
		lr_s1      <= DIFF_W'(l_c) + DIFF_W'(r_c);
		bt_s1      <= DIFF_W'(b_c) + DIFF_W'(t_c);
		fn_s1      <= DIFF_W'(f_c) + DIFF_W'(n_c);
		dx_s1      <= DIFF_W'(r_c) - DIFF_W'(l_c);
		dy_s1      <= DIFF_W'(t_c) - DIFF_W'(b_c);
		dz_s1      <= DIFF_W'(f_c) - DIFF_W'(n_c);
		invalid_s1 <= (r_c == l_c) || (t_c == b_c) || (n_c == f_c);
	end

	// Second stage: the products that make up the matrix entries.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pnr_s2[i]  <= n_s1 * rt_s1[i];
			plr_s2[i]  <= lr_s1 * nd_s1[i];
			pnu_s2[i]  <= n_s1 * up_s1[i];
			pbt_s2[i]  <= bt_s1 * nd_s1[i];
			pfnd_s2[i] <= fn_s1 * nd_s1[i];
			nd_s2[i]   <= nd_s1[i];
		end
		pfn_s2     <= f_s1 * n_s1;
		dx_s2      <= dx_s1;
		dy_s2      <= dy_s1;
		dz_s2      <= dz_s1;
		invalid_s2 <= invalid_s1;
	end

	// Third stage: scale and combine into the final coefficients.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			coef_s3.cx[i] <= (CX_W'(pnr_s2[i]) <<< 1) - (CX_W'(plr_s2[i]) <<< 12);
			coef_s3.cy[i] <= (CY_W'(pnu_s2[i]) <<< 1) - pbt_s2[i];
			coef_s3.cz[i] <= -pfnd_s2[i];
			coef_s3.cw[i] <= nd_s2[i];
		end
		coef_s3.czw     <= CZW_W'(pfn_s2) <<< 13;
		coef_s3.dx      <= dx_s2;
		coef_s3.dy      <= dy_s2;
		coef_s3.dz      <= dz_s2;
		coef_s3.invalid <= invalid_s2;
	end

	assign eye_position = eye_q;
	assign coef         = coef_s3;
	assign settling     = (settle_q != 2'd0);

endmodule

### hdl/vvp_front.sv
module vvp_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [2:0][vvp_pkg::VTX_W-1:0]    xyz,
	input  logic [vvp_pkg::VTX_W-1:0]         w,
	input  logic [vvp_pkg::CFG_DATA_W-1:0]    eye_position,
	output logic                              push,
	output vvp_pkg::vtx_t                     vtx
);
	import vvp_pkg::*;

	logic  valid_s1;
	vtx_t  vtx_s1;

	// Transaction tracking for the translation stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Translate by minus the eye, scaled by w: x * 2^12 - eye * w.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			vtx_s1.tt[i] <= (TT_W'($signed(xyz[i])) <<< 12)
				- (TT_W'($signed(eye_position[COMP_W*i +: COMP_W])) * TT_W'($signed(w)));
		end
		vtx_s1.w <= w;
	end

	assign push = valid_s1;
	assign vtx  = vtx_s1;

endmodule

### hdl/vvp_fifo.sv
module vvp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic             full
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));

endmodule

### hdl/vvp_mul.sv
module vvp_mul #(
	parameter int WA = 16,
	parameter int WB = 16
) (
	input  logic                    clk,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] p
);
	localparam int HA = WA / 2;
	localparam int HB = WB / 2;
	localparam int PW = WA + WB;

	logic signed [WA-HA+WB-HB-1:0] hh_s1;
	logic signed [WA-HA+HB:0]      hl_s1;
	logic signed [HA+WB-HB:0]      lh_s1;
	logic [HA+HB-1:0]              ll_s1;
	logic signed [PW-1:0]          p_s2;

	// Four half-width partial products.
	always_ff @(posedge clk) begin
		hh_s1 <= $signed(a[WA-1:HA]) * $signed(b[WB-1:HB]);
		hl_s1 <= $signed(a[WA-1:HA]) * $signed({1'b0, b[HB-1:0]});
		lh_s1 <= $signed({1'b0, a[HA-1:0]}) * $signed(b[WB-1:HB]);
		ll_s1 <= a[HA-1:0] * b[HB-1:0];
	end

	// Align and sum the partial products.
	always_ff @(posedge clk) begin
		p_s2 <= (PW'(hh_s1) <<< (HA + HB)) + (PW'(hl_s1) <<< HA)
			+ (PW'(lh_s1) <<< HB) + PW'($signed({1'b0, ll_s1}));
	end

	assign p = p_s2;

endmodule

### hdl/vvp_div.sv
module vvp_div #(
	parameter int K = 24
) (
	input  logic                               clk,
	input  logic signed [vvp_pkg::NUM_W-1:0]   num,
	input  logic signed [vvp_pkg::DIFF_W-1:0]  d,
	output logic [31:0]                        q,
	output logic                               sat
);
	import vvp_pkg::*;

	localparam int AW = NUM_W + 1 - K;
	localparam int HW = AW - QUO_W;

	logic [NUM_W-1:0]  nmag_s1;
	logic [DIFF_W-1:0] dm_s1, dm_s2;
	logic              neg_s1, neg_s2;
	logic [NUM_W:0]    sum_c;
	logic [AW-1:0]     a_s2;

	logic [DIFF_W-1:0] rem_q [QUO_W+1];
	logic [QUO_W-1:0]  quo_q [QUO_W+1];
	logic [QUO_W-1:0]  low_q [QUO_W+1];
	logic [DIFF_W-1:0] dm_q  [QUO_W+1];
	logic              neg_q [QUO_W+1];
	logic              big_q [QUO_W+1];

	logic [31:0]       q_q;
	logic              sat_q;
	logic [QUO_W-1:0]  qf;

	// Magnitudes and the sign of the quotient.
	always_ff @(posedge clk) begin
		nmag_s1 <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		dm_s1   <= d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
		neg_s1  <= num[NUM_W-1] ^ d[DIFF_W-1];
	end

	// Fold the half-step rounding bias and the power-of-two scale in early.
	assign sum_c = {1'b0, nmag_s1} + ((NUM_W + 1)'(dm_s1) << (K - 1));

	always_ff @(posedge clk) begin
		a_s2   <= sum_c[NUM_W:K];
		dm_s2  <= dm_s1;
		neg_s2 <= neg_s1;
	end

	// Overflow check and initial partial remainder.
	always_ff @(posedge clk) begin
		big_q[0] <= (a_s2[AW-1:QUO_W] >= HW'(dm_s2));
		rem_q[0] <= a_s2[QUO_W+DIFF_W-1:QUO_W];
		low_q[0] <= a_s2[QUO_W-1:0];
		quo_q[0] <= '0;
		dm_q[0]  <= dm_s2;
		neg_q[0] <= neg_s2;
	end

	// One quotient bit per stage, restoring division.
	for (genvar j = 0; j < QUO_W; j++) begin : g_step
		logic [DIFF_W:0] trial;
		logic            ge;

		assign trial = {rem_q[j], low_q[j][QUO_W-1-j]};
		assign ge    = (trial >= {1'b0, dm_q[j]});

		always_ff @(posedge clk) begin
			rem_q[j+1] <= ge ? DIFF_W'(trial - {1'b0, dm_q[j]}) : DIFF_W'(trial);
			quo_q[j+1] <= {quo_q[j][QUO_W-2:0], ge};
			low_q[j+1] <= low_q[j];
			dm_q[j+1]  <= dm_q[j];
			neg_q[j+1] <= neg_q[j];
			big_q[j+1] <= big_q[j];
		end
	end

	assign qf = quo_q[QUO_W];

	// Apply the sign and clamp to the 32-bit range.
	always_ff @(posedge clk) begin
		if (neg_q[QUO_W]) begin
			if (big_q[QUO_W] || (qf > QUO_W'(SAT_NEG))) begin
				q_q   <= SAT_NEG;
				sat_q <= 1'b1;
			end else begin
				q_q   <= 32'(QUO_W'(0) - qf);
				sat_q <= 1'b0;
			end
		end else begin
			if (big_q[QUO_W] || (qf > QUO_W'(SAT_POS))) begin
				q_q   <= SAT_POS;
				sat_q <= 1'b1;
			end else begin
				q_q   <= qf[31:0];
				sat_q <= 1'b0;
			end
		end
	end

	assign q   = q_q;
	assign sat = sat_q;

endmodule

### hdl/vvp_back.sv
module vvp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  vvp_pkg::vtx_t   vtx,
	input  vvp_pkg::coef_t  coef,
	output logic            done,
	output logic [31:0]     clip_x,
	output logic [31:0]     clip_y,
	output logic [31:0]     clip_z,
	output logic [31:0]     clip_w,
	output logic            frustum_invalid,
	output logic            saturated
);
	import vvp_pkg::*;

	localparam int WQ_W = NUM_W + 1 - SHIFT_YZW;
	localparam int WDLY = DIV_LAT - 1;

	logic signed [CX_W+TT_W-1:0]   px [3];
	logic signed [CY_W+TT_W-1:0]   py [3];
	logic signed [CZ_W+TT_W-1:0]   pz [3];
	logic signed [CW_W+TT_W-1:0]   pw [3];
	logic signed [CZW_W+VTX_W-1:0] pzw;

	logic signed [NUM_W-1:0] nx_s3, ny_s3, nz_s3, nw_s3;
	logic [31:0]             qx, qy, qz, qw;
	logic                    sx, sy, sz, sw;
	logic [BACK_LAT-1:0]     vld_q;

	logic [NUM_W-1:0]        nwmag_s4;
	logic                    nwneg_s4;
	logic [NUM_W:0]          wsum_c;
	logic [WQ_W-1:0]         wq_c;
	logic [31:0]             wq_q [WDLY];
	logic                    wsat_q [WDLY];

	// Matrix-vector products, one multiplier per entry.
	for (genvar i = 0; i < 3; i++) begin : g_row
		vvp_mul #(.WA(CX_W), .WB(TT_W)) u_mx (
			.clk (clk), .a ($signed(coef.cx[i])), .b ($signed(vtx.tt[i])), .p (px[i])
		);
		vvp_mul #(.WA(CY_W), .WB(TT_W)) u_my (
			.clk (clk), .a ($signed(coef.cy[i])), .b ($signed(vtx.tt[i])), .p (py[i])
		);
		vvp_mul #(.WA(CZ_W), .WB(TT_W)) u_mz (
			.clk (clk), .a ($signed(coef.cz[i])), .b ($signed(vtx.tt[i])), .p (pz[i])
		);
		vvp_mul #(.WA(CW_W), .WB(TT_W)) u_mw (
			.clk (clk), .a ($signed(coef.cw[i])), .b ($signed(vtx.tt[i])), .p (pw[i])
		);
	end

	vvp_mul #(.WA(CZW_W), .WB(VTX_W)) u_mzw (
		.clk (clk), .a ($signed(coef.czw)), .b ($signed(vtx.w)), .p (pzw)
	);

	// Accumulate each row into one exact numerator.
	always_ff @(posedge clk) begin
		nx_s3 <= NUM_W'(px[0]) + NUM_W'(px[1]) + NUM_W'(px[2]);
		ny_s3 <= NUM_W'(py[0]) + NUM_W'(py[1]) + NUM_W'(py[2]);
		nz_s3 <= NUM_W'(pz[0]) + NUM_W'(pz[1]) + NUM_W'(pz[2]) + NUM_W'(pzw);
		nw_s3 <= NUM_W'(pw[0]) + NUM_W'(pw[1]) + NUM_W'(pw[2]);
	end

	// Rounded division by the frustum widths.
	vvp_div #(.K(SHIFT_X)) u_dx (
		.clk (clk), .num (nx_s3), .d ($signed(coef.dx)), .q (qx), .sat (sx)
	);
	vvp_div #(.K(SHIFT_YZW)) u_dy (
		.clk (clk), .num (ny_s3), .d ($signed(coef.dy)), .q (qy), .sat (sy)
	);
	vvp_div #(.K(SHIFT_YZW)) u_dz (
		.clk (clk), .num (nz_s3), .d ($signed(coef.dz)), .q (qz), .sat (sz)
	);

	// Clip w only needs a rounded shift: take the magnitude and sign first.
	always_ff @(posedge clk) begin
		nwmag_s4 <= nw_s3[NUM_W-1] ? NUM_W'(-nw_s3) : NUM_W'(nw_s3);
		nwneg_s4 <= nw_s3[NUM_W-1];
	end

	// Half-step bias, ties going away from zero.
	assign wsum_c = {1'b0, nwmag_s4} + ((NUM_W + 1)'(1) << (SHIFT_YZW - 1));
	assign wq_c   = wsum_c[NUM_W:SHIFT_YZW];

	// Sign and clamp, then delay to line up with the dividers.
	always_ff @(posedge clk) begin
		if (nwneg_s4) begin
			if (wq_c > WQ_W'(SAT_NEG)) begin
				wq_q[0]   <= SAT_NEG;
				wsat_q[0] <= 1'b1;
			end else begin
				wq_q[0]   <= 32'd0 - wq_c[31:0];
				wsat_q[0] <= 1'b0;
			end
		end else begin
			if (wq_c > WQ_W'(SAT_POS)) begin
				wq_q[0]   <= SAT_POS;
				wsat_q[0] <= 1'b1;
			end else begin
				wq_q[0]   <= wq_c[31:0];
				wsat_q[0] <= 1'b0;
			end
		end
		for (int k = 1; k < WDLY; k++) begin
			wq_q[k]   <= wq_q[k-1];
			wsat_q[k] <= wsat_q[k-1];
		end
	end

	assign qw = wq_q[WDLY-1];
	assign sw = wsat_q[WDLY-1];

	// Transaction valid bits travel alongside the data path.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[BACK_LAT-2:0], in_valid};
		end
	end

	// A degenerate frustum forces zero outputs.
	assign done            = vld_q[BACK_LAT-1];
	assign clip_x          = coef.invalid ? '0 : qx;
	assign clip_y          = coef.invalid ? '0 : qy;
	assign clip_z          = coef.invalid ? '0 : qz;
	assign clip_w          = coef.invalid ? '0 : qw;
	assign frustum_invalid = coef.invalid;
	assign saturated       = !coef.invalid && (sx || sy || sz || sw);

endmodule

### hdl/vertex_view_projection_transform.sv
// Look-at view and frustum projection of Q16.16 vertices into clip space,
// without the perspective divide. One vertex is taken per clock while busy is
// low, and its result appears on the clip ports with done high for a single
// cycle; the receiver cannot stall, so every result must be captured in the
// cycle it is shown. Throughput is one vertex per cycle while busy is low,
// set by the fully pipelined multipliers and the 33-stage quotient pipeline
// in each of the three frustum dividers; clip w is a rounded shift delayed to
// match them. After every write to a camera register busy stays high while
// the combined matrix coefficients are recomputed; camera registers are to
// be written only when no vertex is in flight.
`include "vertex_view_projection_transform_assert.svh"

module vertex_view_projection_transform (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [31:0]                       vertex_x,
	input  logic [31:0]                       vertex_y,
	input  logic [31:0]                       vertex_z,
	input  logic [31:0]                       vertex_w,
	output logic                              done,
	output logic [31:0]                       clip_x,
	output logic [31:0]                       clip_y,
	output logic [31:0]                       clip_z,
	output logic [31:0]                       clip_w,
	output logic                              frustum_invalid,
	output logic                              saturated,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [vvp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vvp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import vvp_pkg::*;

	logic                  accept;
	logic                  settling;
	logic [CFG_DATA_W-1:0] eye_position;
	coef_t                 coef;
	logic                  push;
	vtx_t                  vtx_front;
	vtx_t                  vtx_queue;
	logic                  q_empty, q_full;

	assign cfg_ready = 1'b1;
	assign busy      = settling || q_full;
	assign accept    = start && !busy;

	// Camera registers and coefficient set-up.
	vvp_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.eye_position (eye_position),
		.coef         (coef),
		.settling     (settling)
	);

	// Front end: accept and translate.
	vvp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.xyz          ({vertex_z, vertex_y, vertex_x}),
		.w            (vertex_w),
		.eye_position (eye_position),
		.push         (push),
		.vtx          (vtx_front)
	);

	// Short queue between the two halves.
	vvp_fifo #(.WIDTH($bits(vtx_t)), .DEPTH(2)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (vtx_front),
		.pop     (!q_empty),
		.rd_data (vtx_queue),
		.empty   (q_empty),
		.full    (q_full)
	);

	// Back end: projection and rounded division.
	vvp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (!q_empty),
		.vtx             (vtx_queue),
		.coef            (coef),
		.done            (done),
		.clip_x          (clip_x),
		.clip_y          (clip_y),
		.clip_z          (clip_z),
		.clip_w          (clip_w),
		.frustum_invalid (frustum_invalid),
		.saturated       (saturated)
	);

	// A register write must block vertices while the coefficients settle.
	`VVP_ASSERT_NEXT(a_cfg_blocks, cfg_valid && cfg_ready, busy)
	// A degenerate frustum never reports saturation.
	`VVP_ASSERT_NOW(a_invalid_no_sat, done && frustum_invalid, !saturated)
	// A degenerate frustum gives all-zero clip coordinates.
	`VVP_ASSERT_NOW(a_invalid_zero, done && frustum_invalid, (clip_x | clip_y | clip_z | clip_w) == 32'd0)
	// The queue never overflows.
	`VVP_ASSERT_NOW(a_queue_safe, push && q_full, 1'b0)

endmodule
